// File: rtl/nlms_pkg.sv
// Shared types and constants for the NLMS echo canceller core.
`default_nettype none
package nlms_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int WEIGHT_W  = 32;
   localparam int POWER_W   = 40;
   localparam int DEN_W     = 41;
   localparam int ACC_W     = 64;
   localparam int TAPS_W    = 10;
   localparam int STEP_W    = 17;
   localparam int REGU_W    = 31;
   localparam int LEAK_W    = 17;
   localparam int CSR_IDX_W = 3;
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 18;
   localparam int MUL_P_W   = 51;
   localparam int DIV_NUM_W = 60;
   localparam int DIV_Q_W   = 34;
   localparam int DIV_CNT_W = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAPS  = 3'd0,
      CSR_STEP  = 3'd1,
      CSR_REGU  = 3'd2,
      CSR_LEAK  = 3'd3,
      CSR_NORM  = 3'd4,
      CSR_CLEAR = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_CLR_ALL,
      ST_IDLE,
      ST_CLR_HIST,
      ST_MOD,
      ST_PW_RD,
      ST_PW_OLD,
      ST_PW_SUB,
      ST_PW_ADD,
      ST_PW_THR,
      ST_FIR_RD,
      ST_FIR_MUL,
      ST_FIR_ACC,
      ST_EST,
      ST_UPD_RD,
      ST_UPD_EX,
      ST_UPD_LK,
      ST_UPD_MU,
      ST_UPD_DV,
      ST_UPD_WT,
      ST_UPD_WR,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// File: rtl/nlms_div.sv
// Restoring divider, one quotient bit per cycle, quotient clamped on overflow.
`default_nettype none
module nlms_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [nlms_pkg::DIV_NUM_W-1:0]      num,
   input  wire logic [nlms_pkg::DEN_W-1:0]          den,
   output logic      [nlms_pkg::DIV_Q_W:0]          quot,
   output logic                                     done,
   output logic                                     busy
);

   localparam int NW = nlms_pkg::DIV_NUM_W;
   localparam int QW = nlms_pkg::DIV_Q_W;
   localparam int DW = nlms_pkg::DEN_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [nlms_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] lo_ff, lo_in;
   logic [QW:0]   q_ff, q_in;
   logic [DW:0]   trial;
   logic [DW-1:0] top_bits;

   assign top_bits = DW'(num[NW-1:QW]);
   assign trial    = {rem_ff, lo_ff[QW-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      if (start) begin
         q_in = '0;
         if (top_bits >= den) begin
            // quotient would not fit: hand back the clamp value
            q_in    = (QW+1)'(1) << QW;
            done_in = 1'b1;
         end else begin
            rem_in  = top_bits;
            lo_in   = num[QW-1:0];
            cnt_in  = nlms_pkg::DIV_CNT_W'(QW);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, den}) begin
            rem_in = DW'(trial - {1'b0, den});
            q_in   = {q_ff[QW-1:0], 1'b1};
         end else begin
            rem_in = DW'(trial);
            q_in   = {q_ff[QW-1:0], 1'b0};
         end
         lo_in  = lo_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == nlms_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
   end

   assign quot = q_ff;
   assign done = done_ff;
   assign busy = busy_ff;

   property p_no_restart;
      @(posedge clock) disable iff (reset) busy_ff |-> !start;
   endproperty
   a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

   property p_done_ends_busy;
      @(posedge clock) disable iff (reset) $fell(busy_ff) |-> done_ff;
   endproperty
   a_done_ends_busy: assert property (p_done_ends_busy) else $error("busy fell without done");

   property p_rem_below_den;
      @(posedge clock) disable iff (reset) busy_ff && $stable(den) |-> rem_ff < den;
   endproperty
   a_rem_below_den: assert property (p_rem_below_den) else $error("remainder out of range");

endmodule
`default_nettype wire

// File: rtl/nlms_echo_canceller_core.sv
// Top level of the NLMS adaptive echo canceller core.
`default_nettype none
// NLMS echo canceller: each request carries a near-end (microphone) and a
// far-end (loudspeaker) Q1.15 sample. The far sample replaces the oldest
// entry of a circular history of L taps, a running power sum is updated,
// the echo estimate is the Q4.28 weight vector dotted with the history
// (newest first) and the error near minus estimate is returned saturated.
// When adapt is set and the power exceeds regularization * L, every weight
// is leaked and moved along error * sample, scaled by step/(power+delta)
// in NLMS mode or by the fixed step in LMS mode. All work goes through one
// shared 33x18 multiplier and one restoring divider under a sequencer, so
// one request is taken at a time; req_stall is high while it is worked on.
// Work per request, L = effective tap count: the FIR pass over all L taps,
//   each read, multiplied and accumulated in turn; with adaptation an
//   update pass over all L taps, where in NLMS mode each tap waits on the
//   divider for its 34 quotient bits (not when the quotient clamps); a
//   history clear when block_start clears the history; one subtraction of
//   L per step while the write position lies beyond a shrunken tap count;
//   and any stalls of the result channel.
// After reset a clearing pass zeroes both memories; requests are held off
// meanwhile, configuration writes are taken as ever. The user must write
// configuration registers only while the core is idle; it is not enforced.
module nlms_echo_canceller_core #(
   parameter int MAX_TAPS = 512
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [nlms_pkg::SAMPLE_W-1:0]   req_near_sample,
   input  wire logic signed [nlms_pkg::SAMPLE_W-1:0]   req_far_sample,
   input  wire logic                                   req_adapt,
   input  wire logic                                   req_block_start,
   // result channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [nlms_pkg::SAMPLE_W-1:0]        rsp_error_sample,
   output logic signed [nlms_pkg::SAMPLE_W-1:0]        rsp_echo_estimate,
   output logic                                        rsp_adapted,
   // configuration write port
   input  wire logic                                   csr_write_enable,
   input  wire logic [nlms_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [nlms_pkg::REGU_W-1:0]            csr_write_data
);

   localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int LW   = AW + 1;
   localparam int CW   = (LW > nlms_pkg::TAPS_W) ? LW : nlms_pkg::TAPS_W;
   localparam int SW   = nlms_pkg::SAMPLE_W;
   localparam int WW   = nlms_pkg::WEIGHT_W;
   localparam int PW   = nlms_pkg::POWER_W;
   localparam int AAW  = nlms_pkg::MUL_A_W;
   localparam int BBW  = nlms_pkg::MUL_B_W;
   localparam int PPW  = nlms_pkg::MUL_P_W;
   localparam int QW   = nlms_pkg::DIV_Q_W;
   localparam int THW  = 44;
   localparam int LKW  = 35;
   localparam int SUMW = 37;

   // saturate a wide signed value to a 16-bit sample
   function automatic logic signed [SW-1:0] sat16(input logic signed [38:0] v);
      if (v > 39'sd32767)       sat16 = 16'sh7FFF;
      else if (v < -39'sd32768) sat16 = 16'sh8000;
      else                      sat16 = v[SW-1:0];
   endfunction

   function automatic logic signed [WW-1:0] sat32(input logic signed [SUMW-1:0] v);
      if (v > SUMW'(64'sh7FFF_FFFF))        sat32 = 32'sh7FFF_FFFF;
      else if (v < -SUMW'(64'sh8000_0000))  sat32 = 32'sh8000_0000;
      else                                  sat32 = v[WW-1:0];
   endfunction

   nlms_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [nlms_pkg::TAPS_W-1:0] taps_ff;
   logic [nlms_pkg::STEP_W-1:0] step_ff;
   logic [nlms_pkg::REGU_W-1:0] regu_ff;
   logic [nlms_pkg::LEAK_W-1:0] leak_ff;
   logic                        norm_ff;
   logic                        clr_ff;

   // latched request
   logic signed [SW-1:0] near_ff, far_ff;
   logic                 adapt_ff, bstart_ff;

   // sequencer and datapath state
   logic [AW-1:0]              pos_ff, k_ff, idx_ff, clr_cnt_ff;
   logic [PW-1:0]              power_ff;
   logic signed [PW+1:0]       pw_tmp_ff;
   logic [THW-1:0]             thr_ff;
   logic [nlms_pkg::DEN_W-1:0] den_ff;
   logic signed [nlms_pkg::ACC_W-1:0] acc_ff;
   logic signed [SW-1:0]       err_sat_ff, est_sat_ff;
   logic                       adapted_ff;
   logic signed [WW-1:0]       w_ff, ex_ff;
   logic signed [LKW-1:0]      lw_ff;
   logic [QW:0]                dwmag_ff;
   logic signed [PPW-1:0]      mul_p_ff;

   // result register
   logic                 rsp_valid_ff;
   logic signed [SW-1:0] rsp_err_ff, rsp_est_ff;
   logic                 rsp_adapted_ff;

   // memories
   logic [WW-1:0] weight_mem [MAX_TAPS];
   logic [SW-1:0] hist_mem   [MAX_TAPS];
   logic [WW-1:0] w_rd_ff;
   logic [SW-1:0] h_rd_ff;
   logic [AW-1:0] w_addr, h_addr;
   logic          w_we, h_we;
   logic [WW-1:0] w_wdata;
   logic [SW-1:0] h_wdata;

   // shared multiplier
   logic signed [AAW-1:0] mul_a;
   logic signed [BBW-1:0] mul_b;
   logic signed [PPW-1:0] mul_full;

   // divider
   logic                            div_start;
   logic                            div_done;
   logic [nlms_pkg::DIV_NUM_W-1:0]  div_num;
   logic [QW:0]                     div_q;
   logic                            div_busy;

   // derived values
   logic [CW-1:0]  taps_x, l_cw;
   logic [LW-1:0]  l_eff;
   logic [AW-1:0]  l_last;
   logic           last_tap;
   logic [AW-1:0]  idx_next;
   logic           req_take, rsp_load;
   logic           clr_last;
   logic signed [PW+1:0] pw_sum;
   logic [PW-1:0]  pw_clamp;
   logic [nlms_pkg::ACC_W-1:0] acc_mag;
   logic [36:0]    est_mag;
   logic signed [38:0] est_s, err_s;
   logic           do_adapt;
   logic [PPW-1:0] lk_mag;
   logic [LKW-2:0] lk_rnd;
   logic [46:0]    mu_mag;
   logic [30:0]    ex_abs;
   logic signed [QW+1:0] dw_s;
   logic signed [SUMW-1:0] w_sum;

   // effective tap count: zero acts as one, beyond the memory acts as full
   assign taps_x   = CW'(taps_ff);
   assign l_cw     = (taps_x == '0) ? CW'(1) :
                     (taps_x > CW'(MAX_TAPS)) ? CW'(MAX_TAPS) : taps_x;
   assign l_eff    = l_cw[LW-1:0];
   assign l_last   = AW'(l_eff - 1'b1);
   assign last_tap = (k_ff == l_last);
   assign idx_next = (idx_ff == '0) ? l_last : idx_ff - 1'b1;
   assign clr_last = (clr_cnt_ff == AW'(MAX_TAPS - 1));

   assign req_take = req_valid && !req_stall;
   assign rsp_load = (state_ff == nlms_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // power: drop the old square, add the new one, clamp to the 40-bit range
   assign pw_sum   = pw_tmp_ff + $signed({1'b0, mul_p_ff[PW:0]});
   assign pw_clamp = (pw_sum < 0) ? '0 :
                     (pw_sum > $signed({2'b00, {PW{1'b1}}})) ? {PW{1'b1}} :
                     pw_sum[PW-1:0];

   // estimate: round the accumulator by 2^28, ties away from zero
   assign acc_mag = acc_ff[nlms_pkg::ACC_W-1] ? nlms_pkg::ACC_W'(-acc_ff)
                                             : nlms_pkg::ACC_W'(acc_ff);
   assign est_mag = 37'((acc_mag + 64'd134217728) >> 28);
   assign est_s   = acc_ff[nlms_pkg::ACC_W-1] ? -$signed({2'b00, est_mag})
                                             :  $signed({2'b00, est_mag});
   assign err_s   = 39'(near_ff) - est_s;
   assign do_adapt = adapt_ff && (THW'(power_ff) > thr_ff);

   // leaked weight: round w * leakage by 2^16
   assign lk_mag = mul_p_ff[PPW-1] ? PPW'(-mul_p_ff) : PPW'(mul_p_ff);
   assign lk_rnd = (LKW-1)'((lk_mag + PPW'(32768)) >> 16);

   assign ex_abs = ex_ff[WW-1] ? 31'(-ex_ff) : 31'(ex_ff);
   assign mu_mag = mul_p_ff[46:0];
   assign div_num = (nlms_pkg::DIV_NUM_W'(mu_mag) << 12)
                  + nlms_pkg::DIV_NUM_W'(den_ff >> 1);

   assign dw_s  = ex_ff[WW-1] ? -$signed({1'b0, dwmag_ff}) : $signed({1'b0, dwmag_ff});
   assign w_sum = SUMW'(lw_ff) + SUMW'(dw_s);

   assign mul_full = PPW'(mul_a) * PPW'(mul_b);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nlms_pkg::ST_CLR_ALL:  if (clr_last) state_in = nlms_pkg::ST_IDLE;
         nlms_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = (req_block_start && clr_ff) ? nlms_pkg::ST_CLR_HIST
                                                      : nlms_pkg::ST_MOD;
            end
         end
         nlms_pkg::ST_CLR_HIST: if (clr_last) state_in = nlms_pkg::ST_MOD;
         nlms_pkg::ST_MOD: begin
            if ({1'b0, pos_ff} < l_eff) state_in = nlms_pkg::ST_PW_RD;
         end
         nlms_pkg::ST_PW_RD:   state_in = nlms_pkg::ST_PW_OLD;
         nlms_pkg::ST_PW_OLD:  state_in = nlms_pkg::ST_PW_SUB;
         nlms_pkg::ST_PW_SUB:  state_in = nlms_pkg::ST_PW_ADD;
         nlms_pkg::ST_PW_ADD:  state_in = nlms_pkg::ST_PW_THR;
         nlms_pkg::ST_PW_THR:  state_in = nlms_pkg::ST_FIR_RD;
         nlms_pkg::ST_FIR_RD:  state_in = nlms_pkg::ST_FIR_MUL;
         nlms_pkg::ST_FIR_MUL: state_in = nlms_pkg::ST_FIR_ACC;
         nlms_pkg::ST_FIR_ACC: state_in = last_tap ? nlms_pkg::ST_EST : nlms_pkg::ST_FIR_RD;
         nlms_pkg::ST_EST:     state_in = do_adapt ? nlms_pkg::ST_UPD_RD : nlms_pkg::ST_DONE;
         nlms_pkg::ST_UPD_RD:  state_in = nlms_pkg::ST_UPD_EX;
         nlms_pkg::ST_UPD_EX:  state_in = nlms_pkg::ST_UPD_LK;
         nlms_pkg::ST_UPD_LK:  state_in = nlms_pkg::ST_UPD_MU;
         nlms_pkg::ST_UPD_MU:  state_in = nlms_pkg::ST_UPD_DV;
         nlms_pkg::ST_UPD_DV:  state_in = norm_ff ? nlms_pkg::ST_UPD_WT : nlms_pkg::ST_UPD_WR;
         nlms_pkg::ST_UPD_WT:  if (div_done) state_in = nlms_pkg::ST_UPD_WR;
         nlms_pkg::ST_UPD_WR:  state_in = last_tap ? nlms_pkg::ST_DONE : nlms_pkg::ST_UPD_RD;
         nlms_pkg::ST_DONE:    if (rsp_load) state_in = nlms_pkg::ST_IDLE;
         default:              state_in = nlms_pkg::ST_IDLE;
      endcase
   end

   // memory ports, multiplier operands, divider start
   always_comb begin
      w_addr    = '0;
      h_addr    = '0;
      w_we      = 1'b0;
      h_we      = 1'b0;
      w_wdata   = '0;
      h_wdata   = '0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      unique case (state_ff)
         nlms_pkg::ST_CLR_ALL: begin
            w_addr = clr_cnt_ff;
            h_addr = clr_cnt_ff;
            w_we   = 1'b1;
            h_we   = 1'b1;
         end
         nlms_pkg::ST_CLR_HIST: begin
            h_addr = clr_cnt_ff;
            h_we   = 1'b1;
         end
         nlms_pkg::ST_PW_RD: h_addr = pos_ff;
         nlms_pkg::ST_PW_OLD: begin
            mul_a = AAW'($signed(h_rd_ff));
            mul_b = BBW'($signed(h_rd_ff));
         end
         nlms_pkg::ST_PW_SUB: begin
            mul_a = AAW'(far_ff);
            mul_b = BBW'(far_ff);
         end
         nlms_pkg::ST_PW_ADD: begin
            h_addr  = pos_ff;
            h_we    = 1'b1;
            h_wdata = far_ff;
            mul_a   = $signed({2'b00, regu_ff});
            mul_b   = $signed(BBW'(l_eff));
         end
         nlms_pkg::ST_FIR_RD, nlms_pkg::ST_UPD_RD: begin
            w_addr = k_ff;
            h_addr = idx_ff;
         end
         nlms_pkg::ST_FIR_MUL: begin
            mul_a = AAW'($signed(w_rd_ff));
            mul_b = BBW'($signed(h_rd_ff));
         end
         nlms_pkg::ST_UPD_EX: begin
            mul_a = AAW'(err_sat_ff);
            mul_b = BBW'($signed(h_rd_ff));
         end
         nlms_pkg::ST_UPD_LK: begin
            mul_a = AAW'(w_ff);
            mul_b = $signed({1'b0, leak_ff});
         end
         nlms_pkg::ST_UPD_MU: begin
            mul_a = $signed({2'b00, ex_abs});
            mul_b = $signed({1'b0, step_ff});
         end
         nlms_pkg::ST_UPD_DV: div_start = norm_ff;
         nlms_pkg::ST_UPD_WR: begin
            w_addr  = k_ff;
            w_we    = 1'b1;
            w_wdata = sat32(w_sum);
         end
         default: ;
      endcase
   end

   // memories: one port each, registered read data
   always_ff @(posedge clock) begin
      if (w_we) weight_mem[w_addr] <= w_wdata;
      w_rd_ff <= weight_mem[w_addr];
      if (h_we) hist_mem[h_addr] <= h_wdata;
      h_rd_ff <= hist_mem[h_addr];
   end

   nlms_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .quot  (div_q),
      .done  (div_done),
      .busy  (div_busy)
   );

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nlms_pkg::ST_CLR_ALL;
         clr_cnt_ff   <= '0;
         pos_ff       <= '0;
         power_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         taps_ff      <= nlms_pkg::TAPS_W'(512);
         step_ff      <= nlms_pkg::STEP_W'(32768);
         regu_ff      <= nlms_pkg::REGU_W'(1074);
         leak_ff      <= nlms_pkg::LEAK_W'(65536);
         norm_ff      <= 1'b1;
         clr_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               nlms_pkg::CSR_TAPS:  taps_ff <= csr_write_data[nlms_pkg::TAPS_W-1:0];
               nlms_pkg::CSR_STEP:  step_ff <= csr_write_data[nlms_pkg::STEP_W-1:0];
               nlms_pkg::CSR_REGU:  regu_ff <= csr_write_data;
               nlms_pkg::CSR_LEAK:  leak_ff <= csr_write_data[nlms_pkg::LEAK_W-1:0];
               nlms_pkg::CSR_NORM:  norm_ff <= csr_write_data[0];
               nlms_pkg::CSR_CLEAR: clr_ff  <= csr_write_data[0];
               default: ;
            endcase
         end
         // sweep counter for both clearing passes
         if (state_ff == nlms_pkg::ST_CLR_ALL || state_ff == nlms_pkg::ST_CLR_HIST) begin
            clr_cnt_ff <= clr_last ? '0 : clr_cnt_ff + 1'b1;
         end
         if (req_take && req_block_start && clr_ff) begin
            pos_ff   <= '0;
            power_ff <= '0;
         end
         // bring a stale write position back below a shrunken tap count
         if (state_ff == nlms_pkg::ST_MOD && {1'b0, pos_ff} >= l_eff) begin
            pos_ff <= AW'({1'b0, pos_ff} - l_eff);
         end
         if (state_ff == nlms_pkg::ST_PW_ADD) power_ff <= pw_clamp;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            pos_ff       <= ({1'b0, pos_ff} + 1'b1 == l_eff) ? '0 : pos_ff + 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mul_p_ff <= mul_full;
      if (req_take) begin
         near_ff   <= req_near_sample;
         far_ff    <= req_far_sample;
         adapt_ff  <= req_adapt;
         bstart_ff <= req_block_start;
      end
      case (state_ff)
         nlms_pkg::ST_PW_SUB: pw_tmp_ff <= $signed({2'b00, power_ff})
                                          - $signed({1'b0, mul_p_ff[PW:0]});
         nlms_pkg::ST_PW_THR: begin
            thr_ff <= mul_p_ff[THW-1:0];
            den_ff <= {1'b0, power_ff} + nlms_pkg::DEN_W'(regu_ff);
            acc_ff <= '0;
            k_ff   <= '0;
            idx_ff <= pos_ff;
         end
         nlms_pkg::ST_FIR_ACC: begin
            acc_ff <= acc_ff + nlms_pkg::ACC_W'(mul_p_ff);
            if (!last_tap) begin
               k_ff   <= k_ff + 1'b1;
               idx_ff <= idx_next;
            end
         end
         nlms_pkg::ST_EST: begin
            est_sat_ff <= sat16(est_s);
            err_sat_ff <= sat16(err_s);
            adapted_ff <= do_adapt;
            k_ff       <= '0;
            idx_ff     <= pos_ff;
         end
         nlms_pkg::ST_UPD_EX: w_ff  <= $signed(w_rd_ff);
         nlms_pkg::ST_UPD_LK: ex_ff <= mul_p_ff[WW-1:0];
         nlms_pkg::ST_UPD_MU: begin
            lw_ff <= mul_p_ff[PPW-1] ? -$signed({1'b0, lk_rnd}) : $signed({1'b0, lk_rnd});
         end
         nlms_pkg::ST_UPD_DV: begin
            if (!norm_ff) dwmag_ff <= (QW+1)'((mu_mag + 47'd131072) >> 18);
         end
         nlms_pkg::ST_UPD_WT: if (div_done) dwmag_ff <= div_q;
         nlms_pkg::ST_UPD_WR: begin
            if (!last_tap) begin
               k_ff   <= k_ff + 1'b1;
               idx_ff <= idx_next;
            end
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_err_ff     <= err_sat_ff;
         rsp_est_ff     <= est_sat_ff;
         rsp_adapted_ff <= adapted_ff;
      end
   end

   assign req_stall         = (state_ff != nlms_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_error_sample  = rsp_err_ff;
   assign rsp_echo_estimate = rsp_est_ff;
   assign rsp_adapted       = rsp_adapted_ff;

   property p_div_only_waiting;
      @(posedge clock) disable iff (reset) div_busy |-> state_ff == nlms_pkg::ST_UPD_WT;
   endproperty
   a_div_only_waiting: assert property (p_div_only_waiting)
      else $error("divider busy outside its wait state");

   property p_take_leaves_idle;
      @(posedge clock) disable iff (reset) req_take |=> state_ff != nlms_pkg::ST_IDLE;
   endproperty
   a_take_leaves_idle: assert property (p_take_leaves_idle)
      else $error("request taken but sequencer stayed idle");

   property p_rsp_from_done;
      @(posedge clock) disable iff (reset)
         $rose(rsp_valid_ff) |-> $past(state_ff) == nlms_pkg::ST_DONE;
   endproperty
   a_rsp_from_done: assert property (p_rsp_from_done)
      else $error("result raised outside the done state");

   property p_pos_in_range;
      @(posedge clock) disable iff (reset)
         state_ff == nlms_pkg::ST_FIR_RD |-> {1'b0, pos_ff} < l_eff && {1'b0, idx_ff} < l_eff;
   endproperty
   a_pos_in_range: assert property (p_pos_in_range)
      else $error("history position beyond tap count");

   property p_bstart_clear;
      @(posedge clock) disable iff (reset)
         state_ff == nlms_pkg::ST_CLR_HIST |-> bstart_ff && clr_ff;
   endproperty
   a_bstart_clear: assert property (p_bstart_clear)
      else $error("history clear without block start");

endmodule
`default_nettype wire
